### sv/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SERVE  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LEFT,
    OP_RIGHT,
    OP_LOAD
  } cell_op_e;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } cell_data_t;

  // broadcast to every cell in the decide cycle
  typedef struct packed {
    logic              en;
    logic              ins;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

### sv/spq_if.sv
`timescale 1ns / 1ps

interface spq_in_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   entry_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, output mode, output entry_id, output priority_req,
                  input ready);
  modport sink (input valid, input mode, input entry_id, input priority_req,
                output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   served_id;
  logic [PRIO_W-1:0] served_priority;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output served_id,
                  output served_priority, output occupancy, input ready);
  modport sink (input valid, input status, input served_id,
                input served_priority, input occupancy, output ready);
endinterface

### sv/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  cell_data_t left_i,
  input  cell_data_t right_i,
  input  logic       ge_i,
  input  logic       found_i,
  output cell_data_t data_o,
  output logic       ge_o,
  output logic       found_o
);

  logic              valid_q, valid_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  cell_op_e          op_q, op_d;
  logic              ge, match;

  assign ge      = valid_q && (prio_q >= cmd_i.prio);
  assign match   = valid_q && (id_q == cmd_i.id);
  assign ge_o    = ge;
  assign found_o = found_i | match;
  assign data_o  = '{valid: valid_q, id: id_q, prio: prio_q};

  always_comb begin
    op_d = OP_HOLD;
    if (cmd_i.en) begin
      if (cmd_i.ins) begin
        // ge cells form a prefix; the first cell past it takes the new entry
        if (!ge) op_d = ge_i ? OP_LOAD : OP_LEFT;
      end else if (found_o) begin
        op_d = OP_RIGHT;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    case (op_q)
      OP_LEFT: begin
        valid_d = left_i.valid;
        id_d    = left_i.id;
        prio_d  = left_i.prio;
      end
      OP_RIGHT: begin
        valid_d = right_i.valid;
        id_d    = right_i.id;
        prio_d  = right_i.prio;
      end
      OP_LOAD: begin
        valid_d = 1'b1;
        id_d    = cmd_i.id;
        prio_d  = cmd_i.prio;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_HOLD;
      valid_q <= 1'b0;
    end else begin
      op_q    <= op_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

endmodule

### sv/stable_priority_queue_with_update_core.sv
`timescale 1ns / 1ps

// sorted priority queue of DEPTH (id, priority) entries held in a chain of cells,
// highest priority at cell 0, equal priorities kept in arrival order.
// in_i carries mode, entry_id and priority_req; out_o returns one result per
// request: status, served_id, served_priority and the occupancy after the request.
// each request takes a decide cycle, where every cell compares itself against the
// request and the first-match and insert-position chains settle, then a shift
// cycle, where each cell holds, loads the new entry or copies a neighbor.
// add, remove and serve take the next request during the shift cycle, so a new
// request is accepted before the last one is through. an update whose delete
// pass succeeds then runs an insert pass and takes the next request in its shift.
// the result appears in the output register the cycle after the final decide.
// a result waiting on a stalled receiver does not block the next request from
// being taken; the final decide cycle of that next request holds until the output
// register is free.
// reset clears the cell valid bits and the count, leaving an empty queue.
module stable_priority_queue_with_update_core import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  spq_in_if.sink   in_i,
  spq_out_if.source out_o
);

  ctrl_state_e       state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [ID_W-1:0]   id_q;
  logic [PRIO_W-1:0] prio_q;
  logic              ins_phase_q, ins_phase_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic [ID_W-1:0]   sid_q, sid_d;
  logic [PRIO_W-1:0] spr_q, spr_d;
  logic [OCC_W-1:0]  occ_q;

  logic       in_xfer, out_free, ok, final_step, commit;
  logic       ins, head_found;
  cell_cmd_t  cmd;

  cell_data_t        data_w  [DEPTH];
  logic [DEPTH-1:0]  ge_w, found_w, valid_vec;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // request decode
  always_comb begin
    ok         = 1'b1;
    ins        = 1'b0;
    head_found = 1'b0;
    status_d   = STAT_OK;
    sid_d      = '0;
    spr_d      = '0;
    unique case (mode_q)
      MODE_ADD: begin
        ins = 1'b1;
        if (count_q == CNT_W'(DEPTH)) begin
          ok       = 1'b0;
          status_d = STAT_FULL;
        end
      end
      MODE_REMOVE, MODE_UPDATE: begin
        if (ins_phase_q) begin
          ins = 1'b1;
        end else if (count_q == '0) begin
          ok       = 1'b0;
          status_d = STAT_EMPTY;
        end else if (!found_w[DEPTH-1]) begin
          ok       = 1'b0;
          status_d = STAT_NOT_FOUND;
        end
      end
      MODE_SERVE: begin
        head_found = 1'b1;
        if (count_q == '0) begin
          ok       = 1'b0;
          status_d = STAT_EMPTY;
        end else begin
          sid_d = data_w[0].id;
          spr_d = data_w[0].prio;
        end
      end
      default: ;
    endcase
  end

  // an update whose delete pass succeeds still has its insert pass to run
  assign final_step = !(mode_q == MODE_UPDATE && !ins_phase_q && ok);

  always_comb begin
    commit = (state_q == S_DECIDE) && (!final_step || out_free);
    in_i.ready = (state_q == S_IDLE) || (state_q == S_SHIFT && !ins_phase_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_DECIDE;
      S_DECIDE: if (commit) state_d = S_SHIFT;
      S_SHIFT:  state_d = (ins_phase_q || in_xfer) ? S_DECIDE : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ins_phase_d = ins_phase_q;
    count_d     = count_q;
    if (commit) begin
      ins_phase_d = !final_step;
      if (ok) count_d = ins ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
    end
  end

  assign cmd = '{en: commit && ok, ins: ins, id: id_q, prio: prio_q};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_data_t left, right;
    logic       ge_in, found_in;
    if (i == 0) begin : g_head
      assign left     = '0;
      assign ge_in    = 1'b1;
      assign found_in = head_found;
    end else begin : g_body
      assign left     = data_w[i-1];
      assign ge_in    = ge_w[i-1];
      assign found_in = found_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = data_w[i+1];
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .ge_i    (ge_in),
      .found_i (found_in),
      .data_o  (data_w[i]),
      .ge_o    (ge_w[i]),
      .found_o (found_w[i])
    );
    assign valid_vec[i] = data_w[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ins_phase_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ins_phase_q <= ins_phase_d;
      count_q     <= count_d;
      if (commit && final_step) out_valid_q <= 1'b1;
      else if (out_o.ready)     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= in_i.mode;
      id_q   <= in_i.entry_id;
      prio_q <= in_i.priority_req;
    end
    if (commit && final_step) begin
      status_q <= status_d;
      sid_q    <= sid_d;
      spr_q    <= spr_d;
      // the count can move on while this result waits
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.served_id       = sid_q;
  assign out_o.served_priority = spr_q;
  assign out_o.occupancy       = occ_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // valid cells must match the count once the shift has landed
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_SHIFT |-> $countones(valid_vec) == 32'(count_q))
    else $error("cell valid bits disagree with count");

  a_result_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DECIDE))
    else $error("result without a decide cycle");

  a_insert_pass_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_phase_q |-> state_q != S_IDLE && !in_i.ready)
    else $error("pending insert pass while idle or accepting");

endmodule
